@@ rtl/fsd_pkg.sv @@
// Shared types and constants for the flux stream decoder.
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int CAP_DEPTH = 12;

  localparam logic [7:0]  OP_FLUX1_MAX = 8'h07;
  localparam logic [7:0]  OP_FLUX2     = 8'h08;
  localparam logic [7:0]  OP_FLUX3     = 8'h09;
  localparam logic [7:0]  OP_OVERFLOW  = 8'h0A;
  localparam logic [7:0]  OP_VALUE3    = 8'h0B;
  localparam logic [7:0]  OP_OOB       = 8'h0D;
  localparam logic [7:0]  BLK_INDEX    = 8'h02;
  localparam logic [7:0]  BLK_END      = 8'h03;
  localparam logic [31:0] OVERFLOW_STEP = 32'h0001_0000;
  localparam logic [31:0] FLUX2_BASE    = 32'd8;
  localparam logic [15:0] INDEX_MIN_LEN = 16'd12;
  localparam logic [15:0] END_MIN_LEN   = 16'd8;

  typedef enum logic [3:0] {
    PH_OP,
    PH_F2,
    PH_F3_HI,
    PH_F3_LO,
    PH_V3_A,
    PH_V3_B,
    PH_B_TYPE,
    PH_B_LEN_LO,
    PH_B_LEN_HI,
    PH_B_DATA
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FLUX,
    KIND_INDEX,
    KIND_END,
    KIND_NOTHING,
    KIND_TRUNC
  } kind_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] interval_ticks;
    logic [47:0] elapsed_ticks;
    logic [31:0] block_position;
    logic [31:0] index_samples;
    logic [31:0] index_number;
    logic [31:0] end_code;
    logic        final_res;
  } result_t;

endpackage

@@ rtl/fsd_in_reg.sv @@
// Input register stage holding one stream byte for the decoder.
`timescale 1ns / 1ps

module fsd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    stream_byte,
  input  logic          is_last,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  logic          take,
  output logic          item_valid,
  output fsd_pkg::item_t item
);
  import fsd_pkg::*;

  assign byte_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_ready) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      item.stream_byte <= stream_byte;
      item.is_last     <= is_last;
    end
  end

endmodule

@@ rtl/fsd_core.sv @@
// Decoder state and next-state logic: one byte decoded per transfer.
`timescale 1ns / 1ps

module fsd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  fsd_pkg::item_t   item,
  input  logic             space,
  output logic             take,
  output logic             emit,
  output fsd_pkg::result_t result
);
  import fsd_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] carry, carry_next;
  logic [47:0] tick_total, tick_total_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [7:0]  block_type, block_type_next;
  logic [15:0] block_length, block_length_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  cap [CAP_DEPTH];
  logic [7:0]  cap_next [CAP_DEPTH];

  logic [7:0]  b;
  logic        flux;
  logic        done_blk;
  logic        hit;
  logic [31:0] base;
  logic [31:0] iv;
  logic [15:0] off;

  assign take = item_valid && space;
  assign b    = item.stream_byte;
  assign off  = block_length - bytes_left;
  assign iv   = carry + base;

  always_comb begin
    phase_next        = phase;
    carry_next        = carry;
    tick_total_next   = tick_total;
    high_byte_next    = high_byte;
    block_type_next   = block_type;
    block_length_next = block_length;
    bytes_left_next   = bytes_left;
    cap_next          = cap;
    flux              = 1'b0;
    done_blk          = 1'b0;
    hit               = 1'b0;
    base              = '0;

    case (phase)
      PH_F2: begin
        flux = 1'b1;
        base = {24'd0, b} + FLUX2_BASE;
      end
      PH_F3_HI: begin
        high_byte_next = b;
        phase_next     = PH_F3_LO;
      end
      PH_F3_LO: begin
        flux = 1'b1;
        base = {16'd0, high_byte, b};
      end
      PH_V3_A: phase_next = PH_V3_B;
      PH_V3_B: phase_next = PH_OP;
      PH_B_TYPE: begin
        block_type_next = b;
        phase_next      = PH_B_LEN_LO;
      end
      PH_B_LEN_LO: begin
        block_length_next = {8'd0, b};
        phase_next        = PH_B_LEN_HI;
      end
      PH_B_LEN_HI: begin
        block_length_next = {b, block_length[7:0]};
        bytes_left_next   = {b, block_length[7:0]};
        for (int i = 0; i < CAP_DEPTH; i++) cap_next[i] = '0;
        if ({b, block_length[7:0]} == 16'd0) begin
          done_blk = 1'b1;
        end else begin
          phase_next = PH_B_DATA;
        end
      end
      PH_B_DATA: begin
        for (int i = 0; i < CAP_DEPTH; i++) begin
          if (off == 16'(i)) cap_next[i] = b;
        end
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left_next == 16'd0) done_blk = 1'b1;
      end
      default: begin
        phase_next = PH_OP;
        if (b <= OP_FLUX1_MAX) begin
          flux = 1'b1;
          base = {24'd0, b} + 32'd1;
        end else if (b == OP_FLUX2) begin
          phase_next = PH_F2;
        end else if (b == OP_FLUX3) begin
          phase_next = PH_F3_HI;
        end else if (b == OP_OVERFLOW) begin
          carry_next = carry + OVERFLOW_STEP;
        end else if (b == OP_VALUE3) begin
          phase_next = PH_V3_A;
        end else if (b == OP_OOB) begin
          phase_next = PH_B_TYPE;
        end
      end
    endcase

    if (flux) begin
      carry_next      = '0;
      tick_total_next = tick_total + {16'd0, iv};
      phase_next      = PH_OP;
    end
    if (done_blk) phase_next = PH_OP;

    result                = '0;
    result.kind           = KIND_FLUX;
    result.interval_ticks = flux ? iv : 32'd0;
    result.elapsed_ticks  = tick_total_next;
    if (flux) hit = 1'b1;
    if (done_blk && block_type_next == BLK_INDEX) begin
      hit         = 1'b1;
      result.kind = KIND_INDEX;
      if (block_length_next >= INDEX_MIN_LEN) begin
        result.block_position = {cap_next[3], cap_next[2], cap_next[1], cap_next[0]};
        result.index_samples  = {cap_next[7], cap_next[6], cap_next[5], cap_next[4]};
        result.index_number   = {cap_next[11], cap_next[10], cap_next[9], cap_next[8]};
      end
    end
    if (done_blk && block_type_next == BLK_END) begin
      hit         = 1'b1;
      result.kind = KIND_END;
      if (block_length_next >= END_MIN_LEN) begin
        result.block_position = {cap_next[3], cap_next[2], cap_next[1], cap_next[0]};
        result.end_code       = {cap_next[7], cap_next[6], cap_next[5], cap_next[4]};
      end
    end

    emit = hit;
    if (item.is_last) begin
      emit             = 1'b1;
      result.final_res = 1'b1;
      if (!hit) result.kind = (phase_next == PH_OP) ? KIND_NOTHING : KIND_TRUNC;
      // end of stream: back to the reset state
      phase_next        = PH_OP;
      carry_next        = '0;
      tick_total_next   = '0;
      high_byte_next    = '0;
      block_type_next   = '0;
      block_length_next = '0;
      bytes_left_next   = '0;
      for (int i = 0; i < CAP_DEPTH; i++) cap_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OP;
      carry        <= '0;
      tick_total   <= '0;
      high_byte    <= '0;
      block_type   <= '0;
      block_length <= '0;
      bytes_left   <= '0;
      for (int i = 0; i < CAP_DEPTH; i++) cap[i] <= '0;
    end else if (take) begin
      phase        <= phase_next;
      carry        <= carry_next;
      tick_total   <= tick_total_next;
      high_byte    <= high_byte_next;
      block_type   <= block_type_next;
      block_length <= block_length_next;
      bytes_left   <= bytes_left_next;
      for (int i = 0; i < CAP_DEPTH; i++) cap[i] <= cap_next[i];
    end
  end

endmodule

@@ rtl/fsd_out_reg.sv @@
// Result register driving the output channel.
`timescale 1ns / 1ps

module fsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fsd_pkg::result_t result,
  output logic             space,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [2:0]       kind,
  output logic [31:0]      interval_ticks,
  output logic [47:0]      elapsed_ticks,
  output logic [31:0]      block_position,
  output logic [31:0]      index_samples,
  output logic [31:0]      index_number,
  output logic [31:0]      end_code,
  output logic             final_res
);
  import fsd_pkg::*;

  result_t res_q;

  assign space = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (space) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= result;
    end
  end

  assign kind           = res_q.kind;
  assign interval_ticks = res_q.interval_ticks;
  assign elapsed_ticks  = res_q.elapsed_ticks;
  assign block_position = res_q.block_position;
  assign index_samples  = res_q.index_samples;
  assign index_number   = res_q.index_number;
  assign end_code       = res_q.end_code;
  assign final_res      = res_q.final_res;

endmodule

@@ rtl/flux_stream_decoder.sv @@
// Flux stream decoder: top level joining input register, decoder and result register.
// Takes one stream byte per cycle and gives at most one result per byte; a byte's
// result is registered and presented in the cycle after its transfer. Throughput is
// one byte every cycle while the result side keeps up, set by the single decode step
// between the input register and the result register. The byte flagged is_last always
// yields a result with final_res set, and then the decoder is back in its reset state.
`timescale 1ns / 1ps

module flux_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  stream_byte,
  input  logic        is_last,
  input  logic        byte_valid,
  output logic        byte_ready,
  output logic [2:0]  kind,
  output logic [31:0] interval_ticks,
  output logic [47:0] elapsed_ticks,
  output logic [31:0] block_position,
  output logic [31:0] index_samples,
  output logic [31:0] index_number,
  output logic [31:0] end_code,
  output logic        final_res,
  output logic        res_valid,
  input  logic        res_ready
);
  import fsd_pkg::*;

  item_t   item;
  result_t result;
  logic    item_valid;
  logic    take;
  logic    emit;
  logic    space;
  logic    load;

  assign load = take && emit;

  fsd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .stream_byte(stream_byte),
    .is_last    (is_last),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  fsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .space     (space),
    .take      (take),
    .emit      (emit),
    .result    (result)
  );

  fsd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .result        (result),
    .space         (space),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .kind          (kind),
    .interval_ticks(interval_ticks),
    .elapsed_ticks (elapsed_ticks),
    .block_position(block_position),
    .index_samples (index_samples),
    .index_number  (index_number),
    .end_code      (end_code),
    .final_res     (final_res)
  );

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> res_valid)
    else $error("loaded result not presented");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    item_valid && !take |=> item_valid && $stable(item))
    else $error("held byte lost");

  a_end_marks_final: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_NOTHING || kind == KIND_TRUNC) |-> final_res)
    else $error("end-of-stream kind without final flag");

  a_no_interval: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_FLUX |-> interval_ticks == 32'd0)
    else $error("interval on non-flux result");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    take && item.is_last |-> emit && result.final_res)
    else $error("last byte without final result");
`endif

endmodule
